// ===== hw/rtl/mde_pkg.sv =====
`default_nettype none

package mde_pkg;

   // register indexes of the configuration port
   localparam logic [1:0] REG_START_BYTES = 2'd0;
   localparam logic [1:0] REG_START_LEN   = 2'd1;
   localparam logic [1:0] REG_END_BYTES   = 2'd2;
   localparam logic [1:0] REG_END_LEN     = 2'd3;

   // result kinds
   localparam logic [1:0] KIND_CONTENT = 2'd0;
   localparam logic [1:0] KIND_DONE    = 2'd1;
   localparam logic [1:0] KIND_DROP    = 2'd2;

   // marker order codes
   localparam logic [1:0] CMP_LT = 2'd0;
   localparam logic [1:0] CMP_EQ = 2'd1;
   localparam logic [1:0] CMP_GT = 2'd2;

   typedef struct packed {
      logic       valid;
      logic       sflag;
      logic       eflag;
      logic [7:0] data;
   } slot_type;

   typedef struct packed {
      logic shift;
      logic clear;
      logic fire_s;
      logic fire_e;
   } cell_ctl_type;

   typedef struct packed {
      logic step;
      logic drop;
   } trk_ctl_type;

   typedef struct packed {
      logic       valid;
      logic [1:0] kind;
      logic [7:0] data;
   } res_type;

   // bytewise order of the two markers, a prefix sorts first
   function automatic logic [1:0] marker_cmp(input logic [63:0] a, input logic [3:0] la,
                                             input logic [63:0] b, input logic [3:0] lb);
      logic [1:0] code;
      logic [3:0] n;
      n = (la < lb) ? la : lb;
      if (la == lb) begin
         code = CMP_EQ;
      end else if (la < lb) begin
         code = CMP_LT;
      end else begin
         code = CMP_GT;
      end
      // walk down so that the lowest differing byte decides
      for (int k = 7; k >= 0; k--) begin
         if ((4'(k) < n) && (a[8*k +: 8] != b[8*k +: 8])) begin
            code = (a[8*k +: 8] < b[8*k +: 8]) ? CMP_LT : CMP_GT;
         end
      end
      return code;
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/mde_cell.sv =====
`default_nettype none

module mde_cell #(
   parameter int IDX = 0
) (
   input  wire                    clock,
   input  wire                    reset,
   input  mde_pkg::cell_ctl_type  ctl,
   input  mde_pkg::slot_type      prev,
   input  wire  [63:0]            start_bytes,
   input  wire  [3:0]             start_len,
   input  wire  [63:0]            end_bytes,
   input  wire  [3:0]             end_len,
   output mde_pkg::slot_type      slot,
   output logic                   hit_s,
   output logic                   hit_e
);

   mde_pkg::slot_type slot_ff;
   mde_pkg::slot_type slot_in;
   logic [2:0] k_s;
   logic [2:0] k_e;

   // compare the byte that lands here on the next shift with the marker byte for this place
   always_comb begin
      k_s   = 3'(start_len - 4'(IDX) - 4'd1);
      k_e   = 3'(end_len - 4'(IDX) - 4'd1);
      hit_s = !(start_len > 4'(IDX))
              || (prev.valid && (prev.data == start_bytes[{k_s, 3'b000} +: 8]));
      hit_e = !(end_len > 4'(IDX))
              || (prev.valid && (prev.data == end_bytes[{k_e, 3'b000} +: 8]));
   end

   always_comb begin
      slot_in = slot_ff;
      if (ctl.clear) begin
         slot_in.valid = 1'b0;
         slot_in.sflag = 1'b0;
         slot_in.eflag = 1'b0;
      end else if (ctl.shift) begin
         slot_in.valid = prev.valid;
         slot_in.data  = prev.data;
         slot_in.sflag = prev.sflag || (ctl.fire_s && (start_len == 4'(IDX + 1)));
         slot_in.eflag = prev.eflag || (ctl.fire_e && (end_len == 4'(IDX + 1)));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff.valid <= 1'b0;
         slot_ff.sflag <= 1'b0;
         slot_ff.eflag <= 1'b0;
      end else begin
         slot_ff.valid <= slot_in.valid;
         slot_ff.sflag <= slot_in.sflag;
         slot_ff.eflag <= slot_in.eflag;
      end
      slot_ff.data <= slot_in.data;
   end

   assign slot = slot_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/mde_track.sv =====
`default_nettype none

module mde_track (
   input  wire                   clock,
   input  wire                   reset,
   input  mde_pkg::trk_ctl_type  ctl,
   input  mde_pkg::slot_type     slot,
   input  wire  [1:0]            cmp,
   input  wire  [3:0]            start_len,
   output mde_pkg::res_type      res
);

   logic       in_msg_ff;
   logic       in_msg_in;
   logic [3:0] skip_ff;
   logic [3:0] skip_in;
   logic       start_first;
   logic       done;
   logic       content;
   logic       in1;
   logic [3:0] skip1;

   always_comb begin
      start_first = (cmp == mde_pkg::CMP_LT) || ((cmp == mde_pkg::CMP_EQ) && !in_msg_ff);
      in1     = in_msg_ff;
      skip1   = skip_ff;
      done    = 1'b0;
      content = 1'b0;
      if (start_first) begin
         if (slot.sflag && !in1) begin
            in1   = 1'b1;
            skip1 = start_len;
         end
         if (slot.eflag && in1) begin
            in1   = 1'b0;
            skip1 = 4'd0;
            done  = 1'b1;
         end
      end else begin
         if (slot.eflag && in1) begin
            in1   = 1'b0;
            skip1 = 4'd0;
            done  = 1'b1;
         end
         if (slot.sflag && !in1) begin
            in1   = 1'b1;
            skip1 = start_len;
         end
      end
      // marker bytes are skipped before content starts
      if (in1) begin
         if (skip1 != 4'd0) begin
            skip1 = skip1 - 4'd1;
         end else begin
            content = 1'b1;
         end
      end

      in_msg_in = in_msg_ff;
      skip_in   = skip_ff;
      res.valid = 1'b0;
      res.kind  = mde_pkg::KIND_CONTENT;
      res.data  = 8'd0;
      if (ctl.drop) begin
         res.valid = in_msg_ff;
         res.kind  = mde_pkg::KIND_DROP;
         in_msg_in = 1'b0;
         skip_in   = 4'd0;
      end else if (ctl.step && slot.valid) begin
         in_msg_in = in1;
         skip_in   = skip1;
         res.valid = done || content;
         res.kind  = done ? mde_pkg::KIND_DONE : mde_pkg::KIND_CONTENT;
         res.data  = content ? slot.data : 8'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_msg_ff <= 1'b0;
         skip_ff   <= 4'd0;
      end else begin
         in_msg_ff <= in_msg_in;
         skip_ff   <= skip_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/marker_delimited_message_extractor.sv =====
`default_nettype none

// Pulls messages out of a byte stream framed by a start marker and an end marker.
// Input channel req_*: one stream byte per transfer, req_buffer_end on the last byte
// of a buffer. Result channel rsp_*: content bytes, a completion item per closed
// message and a drop item for a message still open at buffer end; rsp_last_of_run
// marks the last result caused by one input byte, or by the whole drain after buffer end.
// Markers (1 to MARKER_MAX bytes) are written over csr_*; the user must write them only
// while the block is idle, as the block itself does not enforce it. Bytes sit in a
// chain of MARKER_MAX cells; a content byte leaves MARKER_MAX-1 bytes after it arrives,
// and its result is registered onto rsp_* once the cell holding it reaches the end of
// the chain. Ordinary bytes are taken at one byte per cycle while rsp_* is not stalled.
// A byte with req_buffer_end runs the chain empty one cell per cycle while rsp_* is
// not stalled, then reports and clears before the next byte is taken. When rsp_stall
// holds a result, the processing of the end cell waits, and req_stall rises once a
// byte is waiting there. Reset (synchronous) empties the chain, closes any message
// and sets both markers to a single zero byte.
module marker_delimited_message_extractor #(
   parameter int MARKER_MAX = 8
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_stall,
   input  wire  [7:0]  req_data_byte,
   input  wire         req_buffer_end,
   output logic        rsp_valid,
   input  wire         rsp_stall,
   output logic [1:0]  rsp_kind,
   output logic [7:0]  rsp_content_byte,
   output logic        rsp_last_of_run,
   input  wire         csr_valid,
   output logic        csr_ready,
   input  wire  [1:0]  csr_index,
   input  wire  [63:0] csr_data
);

   localparam int CNT_W = $clog2(MARKER_MAX + 1);

   localparam logic [1:0] ST_RUN   = 2'd0;
   localparam logic [1:0] ST_DRAIN = 2'd1;
   localparam logic [1:0] ST_DROP  = 2'd2;
   localparam logic [1:0] ST_FLUSH = 2'd3;

   logic [63:0] start_bytes_ff;
   logic [3:0]  start_len_ff;
   logic [63:0] end_bytes_ff;
   logic [3:0]  end_len_ff;
   logic [3:0]  ls;
   logic [3:0]  le;
   logic [1:0]  cmp;

   logic [1:0]       state_ff, state_in;
   logic             pend_ff, pend_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [2:0]       sblk_ff, sblk_in;
   logic [2:0]       eblk_ff, eblk_in;

   mde_pkg::res_type hold_ff, hold_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [1:0]       rsp_kind_ff, rsp_kind_in;
   logic [7:0]       rsp_byte_ff, rsp_byte_in;
   logic             rsp_last_ff, rsp_last_in;

   logic go, accept, run_step, drain_step, drop_step, flush;
   logic match_s, match_e;

   mde_pkg::slot_type     head;
   mde_pkg::slot_type     slot_q [MARKER_MAX];
   mde_pkg::cell_ctl_type cell_ctl;
   mde_pkg::trk_ctl_type  trk_ctl;
   mde_pkg::res_type      res;
   logic [MARKER_MAX-1:0] hit_s, hit_e, chain_valid;

   // configuration
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_bytes_ff <= 64'd0;
         start_len_ff   <= 4'd1;
         end_bytes_ff   <= 64'd0;
         end_len_ff     <= 4'd1;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            mde_pkg::REG_START_BYTES: start_bytes_ff <= csr_data;
            mde_pkg::REG_START_LEN:   start_len_ff   <= csr_data[3:0];
            mde_pkg::REG_END_BYTES:   end_bytes_ff   <= csr_data;
            mde_pkg::REG_END_LEN:     end_len_ff     <= csr_data[3:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      ls = (start_len_ff == 4'd0) ? 4'd1
         : (start_len_ff > 4'(MARKER_MAX)) ? 4'(MARKER_MAX) : start_len_ff;
      le = (end_len_ff == 4'd0) ? 4'd1
         : (end_len_ff > 4'(MARKER_MAX)) ? 4'(MARKER_MAX) : end_len_ff;
      cmp = mde_pkg::marker_cmp(start_bytes_ff, ls, end_bytes_ff, le);
   end

   // handshake and step control
   always_comb begin
      go         = !rsp_valid_ff || !rsp_stall;
      req_stall  = (state_ff != ST_RUN) || (pend_ff && !go);
      accept     = req_valid && !req_stall;
      run_step   = (state_ff == ST_RUN) && pend_ff && go;
      drain_step = (state_ff == ST_DRAIN) && go;
      drop_step  = (state_ff == ST_DROP) && go;
      flush      = (state_ff == ST_FLUSH) && go;

      match_s = &hit_s;
      match_e = &hit_e;

      cell_ctl.shift  = accept || drain_step;
      cell_ctl.clear  = flush;
      cell_ctl.fire_s = accept && (sblk_ff == 3'd0) && match_s;
      cell_ctl.fire_e = accept && (eblk_ff == 3'd0) && match_e;

      trk_ctl.step = run_step || drain_step;
      trk_ctl.drop = drop_step;

      head.valid = (state_ff == ST_RUN);
      head.sflag = 1'b0;
      head.eflag = 1'b0;
      head.data  = req_data_byte;
   end

   // cell chain
   for (genvar i = 0; i < MARKER_MAX; i++) begin : g_cell
      mde_pkg::slot_type prev;
      if (i == 0) begin : g_head
         assign prev = head;
      end else begin : g_link
         assign prev = slot_q[i-1];
      end
      mde_cell #(
         .IDX (i)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctl         (cell_ctl),
         .prev        (prev),
         .start_bytes (start_bytes_ff),
         .start_len   (ls),
         .end_bytes   (end_bytes_ff),
         .end_len     (le),
         .slot        (slot_q[i]),
         .hit_s       (hit_s[i]),
         .hit_e       (hit_e[i])
      );
      assign chain_valid[i] = slot_q[i].valid;
   end

   mde_track u_track (
      .clock     (clock),
      .reset     (reset),
      .ctl       (trk_ctl),
      .slot      (slot_q[MARKER_MAX-1]),
      .cmp       (cmp),
      .start_len (ls),
      .res       (res)
   );

   // sequencing and result staging
   always_comb begin
      state_in     = state_ff;
      pend_in      = pend_ff;
      cnt_in       = cnt_ff;
      sblk_in      = sblk_ff;
      eblk_in      = eblk_ff;
      hold_in      = hold_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;

      if (go) begin
         rsp_valid_in = 1'b0;
      end

      // overlap blocking keeps each marker search non-overlapping
      if (accept) begin
         if (sblk_ff != 3'd0) begin
            sblk_in = sblk_ff - 3'd1;
         end else if (match_s) begin
            sblk_in = 3'(ls - 4'd1);
         end
         if (eblk_ff != 3'd0) begin
            eblk_in = eblk_ff - 3'd1;
         end else if (match_e) begin
            eblk_in = 3'(le - 4'd1);
         end
      end

      case (state_ff)
         ST_RUN: begin
            if (run_step) begin
               rsp_valid_in = res.valid;
               rsp_kind_in  = res.kind;
               rsp_byte_in  = res.data;
               rsp_last_in  = 1'b1;
               pend_in      = 1'b0;
            end
            if (accept) begin
               if (req_buffer_end) begin
                  pend_in  = 1'b0;
                  cnt_in   = CNT_W'(MARKER_MAX);
                  state_in = ST_DRAIN;
               end else begin
                  pend_in = 1'b1;
               end
            end
         end
         ST_DRAIN, ST_DROP: begin
            if (go) begin
               // one result is held back until the next one shows whether it was the last
               if (res.valid) begin
                  if (hold_ff.valid) begin
                     rsp_valid_in = 1'b1;
                     rsp_kind_in  = hold_ff.kind;
                     rsp_byte_in  = hold_ff.data;
                     rsp_last_in  = 1'b0;
                  end
                  hold_in = res;
               end
               if (state_ff == ST_DROP) begin
                  state_in = ST_FLUSH;
               end else begin
                  cnt_in = cnt_ff - CNT_W'(1);
                  if (cnt_ff == CNT_W'(1)) begin
                     state_in = ST_DROP;
                  end
               end
            end
         end
         ST_FLUSH: begin
            if (go) begin
               rsp_valid_in  = hold_ff.valid;
               rsp_kind_in   = hold_ff.kind;
               rsp_byte_in   = hold_ff.data;
               rsp_last_in   = 1'b1;
               hold_in.valid = 1'b0;
               sblk_in       = 3'd0;
               eblk_in       = 3'd0;
               state_in      = ST_RUN;
            end
         end
         default: begin
            state_in = ST_RUN;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_RUN;
         pend_ff       <= 1'b0;
         cnt_ff        <= '0;
         sblk_ff       <= 3'd0;
         eblk_ff       <= 3'd0;
         hold_ff.valid <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pend_ff       <= pend_in;
         cnt_ff        <= cnt_in;
         sblk_ff       <= sblk_in;
         eblk_ff       <= eblk_in;
         hold_ff.valid <= hold_in.valid;
         rsp_valid_ff  <= rsp_valid_in;
      end
      hold_ff.kind <= hold_in.kind;
      hold_ff.data <= hold_in.data;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_byte_ff  <= rsp_byte_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_kind         = rsp_kind_ff;
   assign rsp_content_byte = rsp_byte_ff;
   assign rsp_last_of_run  = rsp_last_ff;

   a_drain_stalls_input: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_RUN) |-> req_stall)
      else $error("input taken while the chain drains");

   a_hold_only_in_drain: assert property (@(posedge clock) disable iff (reset)
      hold_ff.valid |-> (state_ff != ST_RUN))
      else $error("held result left over after buffer end");

   a_flush_empties_chain: assert property (@(posedge clock) disable iff (reset)
      flush |=> (chain_valid == '0))
      else $error("chain not empty after buffer end");

   a_drop_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_kind == mde_pkg::KIND_DROP)) |-> rsp_last_of_run)
      else $error("drop item not last of its run");

   a_marker_items_no_byte: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_kind != mde_pkg::KIND_CONTENT)) |-> (rsp_content_byte == 8'd0))
      else $error("completion or drop item carries a byte");

endmodule

`default_nettype wire
